// ===== design/qau_pkg.sv =====
// Shared widths, types and command codes of the quaternion arithmetic unit.
package qau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// operand: one word plus a bit so that a negated minimum still fits
	localparam int OW  = WORD_BITS + 1;
	localparam int PRW = 2 * OW;
	// sum of four products
	localparam int PW  = 2 * WORD_BITS + 3;
	localparam int MW  = PW - 1;
	// squared norm, unsigned
	localparam int NW  = 2 * WORD_BITS + 1;
	// divisor is twice the norm
	localparam int DW  = NW + 1;
	localparam int RW  = DW + 1;
	// quotient and root bits
	localparam int QB  = WORD_BITS + 1;
	localparam int UW  = MW + FRAC_BITS + 2;
	localparam int SW  = NW + 2;
	// latency of a divider or root lane
	localparam int LANE_LAT = QB + 4;

	localparam logic [2:0] CMD_MUL = 3'd0;
	localparam logic [2:0] CMD_INV = 3'd1;
	localparam logic [2:0] CMD_DIV = 3'd2;
	localparam logic [2:0] CMD_REL = 3'd3;
	localparam logic [2:0] CMD_ROT = 3'd4;
	localparam logic [2:0] CMD_MAG = 3'd5;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [OW-1:0]        opnd_t;
	typedef logic signed [PRW-1:0]       prod_t;
	typedef logic signed [PW-1:0]        psum_t;
	typedef logic [NW-1:0]               norm_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		word_t val;
		logic  sat;
	} lane_t;

	typedef struct packed {
		logic       vld;
		logic [2:0] cmd;
		logic       dz;
		logic       tsat;
	} sb_t;

endpackage

// ===== design/quaternion_arith_unit.sv =====
// Top level of the pipelined quaternion arithmetic unit.
//
//  channel   | handshake          | word
//  ----------+--------------------+--------------------------------------------
//  command   | start / busy       | command, first_w..first_z, second_w..second_z
//  result    | done (strobe)      | res_w..res_z, divide_by_zero, saturated
//
// One word is taken every cycle; busy stays low. A result shows on done after
// the two Hamilton product passes, the rounding of the rotated vector, the 33
// quotient and root bit stages and the output register.
// Reset clears the stage control words and done only; the datapath is not reset.
// The receiver cannot stall, so nothing in the pipe ever waits.
module quaternion_arith_unit import qau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  word_t       first_w,
	input  word_t       first_x,
	input  word_t       first_y,
	input  word_t       first_z,
	input  word_t       second_w,
	input  word_t       second_x,
	input  word_t       second_y,
	input  word_t       second_z,
	output logic        done,
	output word_t       res_w,
	output word_t       res_x,
	output word_t       res_y,
	output word_t       res_z,
	output logic        divide_by_zero,
	output logic        saturated
);

	sb_t   sb_s1, sb_s2, sb_s3, sb_s4, sb_s5, sb_s6, sb_s7;
	sb_t   sb_dly_q [LANE_LAT];
	sb_t   sb_o;
	word_t f_s1 [4], s_s1 [4];
	word_t f_s2 [4], f_s3 [4], f_s4 [4], f_s5 [4];
	opnd_t fo [4], fcj [4], so [4], scj [4];
	opnd_t ha_a [4], ha_b [4], hn_a [4], hn_b [4];
	opnd_t hb_a [4], hb_b [4];
	psum_t pa_s3 [4], pn_s3 [4], pb_s7 [4];
	psum_t pa_s4 [4], pa_s5 [4], pa_s6 [4], pa_s7 [4];
	psum_t pa_abs [4];
	norm_t nrm_s3, nrm_s4, nrm_s5, nrm_s6, nrm_s7;
	logic [MW-1:0] tmag_s4 [4];
	logic          tneg_s4 [4];
	logic [MW-1:0] tm [4];
	word_t         t_c [4];
	logic          tsat_c [4];
	word_t         t_s5 [4];
	logic          dz_s3;
	psum_t         pd [4];
	norm_t         nd;
	lane_t         q_o [4];
	lane_t         sq_o;
	word_t         rw_c, rx_c, ry_c, rz_c;
	logic          dz_c, sat_c;
	word_t         res_w_q, res_x_q, res_y_q, res_z_q;
	logic          done_q, dz_q, sat_q;

	assign busy = 1'b0;

	// stage 1: capture the command word
	always_ff @(posedge clk) begin
		f_s1[0] <= first_w;
		f_s1[1] <= first_x;
		f_s1[2] <= first_y;
		f_s1[3] <= first_z;
		s_s1[0] <= second_w;
		s_s1[1] <= second_x;
		s_s1[2] <= second_y;
		s_s1[3] <= second_z;
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			fo[i]   = opnd_t'(f_s1[i]);
			so[i]   = opnd_t'(s_s1[i]);
			fcj[i]  = (i == 0) ? fo[i] : -fo[i];
			scj[i]  = (i == 0) ? so[i] : -so[i];
			ha_a[i] = fo[i];
			ha_b[i] = so[i];
			hn_a[i] = fo[i];
			hn_b[i] = fcj[i];
		end
		case (sb_s1.cmd)
			CMD_INV: begin
				ha_a = fcj;
				ha_b = '{opnd_t'(1) <<< FRAC_BITS, opnd_t'(0), opnd_t'(0), opnd_t'(0)};
			end
			CMD_DIV: begin
				ha_a = scj;
				ha_b = fo;
			end
			CMD_REL: begin
				ha_a = fo;
				ha_b = scj;
			end
			CMD_ROT: begin
				ha_a = '{opnd_t'(0), so[1], so[2], so[3]};
				ha_b = fcj;
			end
			default: begin
			end
		endcase
		if (sb_s1.cmd == CMD_DIV || sb_s1.cmd == CMD_REL) begin
			hn_a = so;
			hn_b = scj;
		end
	end

	// stages 2-3: first product and the squared norm (q times its conjugate)
	qau_hamilton u_ham_a (.clk(clk), .a(ha_a), .b(ha_b), .p(pa_s3));
	qau_hamilton u_ham_n (.clk(clk), .a(hn_a), .b(hn_b), .p(pn_s3));

	assign nrm_s3 = pn_s3[0][NW-1:0];
	assign dz_s3  = (sb_s3.cmd == CMD_INV || sb_s3.cmd == CMD_DIV ||
		sb_s3.cmd == CMD_REL || sb_s3.cmd == CMD_ROT) && (nrm_s3 == '0);

	// stages 4-5: round the vector-times-conjugate product back to words
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pa_abs[i] = pa_s3[i][PW-1] ? -pa_s3[i] : pa_s3[i];
			tm[i]     = tmag_s4[i] >> FRAC_BITS;
			if (tneg_s4[i]) begin
				tsat_c[i] = tm[i] > (MW'(1) << (WORD_BITS - 1));
				t_c[i]    = tsat_c[i] ? WORD_MIN : ('0 - tm[i][WORD_BITS-1:0]);
			end else begin
				tsat_c[i] = tm[i] >= (MW'(1) << (WORD_BITS - 1));
				t_c[i]    = tsat_c[i] ? WORD_MAX : tm[i][WORD_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		f_s2 <= f_s1;
		f_s3 <= f_s2;
		f_s4 <= f_s3;
		f_s5 <= f_s4;
		for (int i = 0; i < 4; i++) begin
			tneg_s4[i] <= pa_s3[i][PW-1];
			tmag_s4[i] <= pa_abs[i][MW-1:0] + (MW'(1) << (FRAC_BITS - 1));
		end
		t_s5   <= t_c;
		pa_s4  <= pa_s3;
		pa_s5  <= pa_s4;
		pa_s6  <= pa_s5;
		pa_s7  <= pa_s6;
		nrm_s4 <= nrm_s3;
		nrm_s5 <= nrm_s4;
		nrm_s6 <= nrm_s5;
		nrm_s7 <= nrm_s6;
	end

	// stages 6-7: second product of the rotation, f times the rounded vector
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			hb_a[i] = opnd_t'(f_s5[i]);
			hb_b[i] = opnd_t'(t_s5[i]);
		end
	end

	qau_hamilton u_ham_b (.clk(clk), .a(hb_a), .b(hb_b), .p(pb_s7));

	// multiply divides by 2^(2F), which is the plain rounding to a word
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pd[i] = (sb_s7.cmd == CMD_ROT) ? pb_s7[i] : pa_s7[i];
		end
		nd = (sb_s7.cmd == CMD_MUL) ? (NW'(1) << (2 * FRAC_BITS)) : nrm_s7;
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		qau_div u_div (.clk(clk), .p(pd[i]), .n(nd), .res(q_o[i]));
	end

	qau_sqrt u_sqrt (.clk(clk), .n(nrm_s7), .res(sq_o));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s1 <= '0;
			sb_s2 <= '0;
			sb_s3 <= '0;
			sb_s4 <= '0;
			sb_s5 <= '0;
			sb_s6 <= '0;
			sb_s7 <= '0;
			for (int i = 0; i < LANE_LAT; i++) begin
				sb_dly_q[i] <= '0;
			end
			done_q <= 1'b0;
		end else begin
			sb_s1      <= '{vld: start, cmd: command, dz: 1'b0, tsat: 1'b0};
			sb_s2      <= sb_s1;
			sb_s3      <= sb_s2;
			sb_s4      <= '{vld: sb_s3.vld, cmd: sb_s3.cmd, dz: dz_s3, tsat: sb_s3.tsat};
			sb_s5      <= '{vld: sb_s4.vld, cmd: sb_s4.cmd, dz: sb_s4.dz,
				tsat: tsat_c[1] | tsat_c[2] | tsat_c[3] | tsat_c[0]};
			sb_s6      <= sb_s5;
			sb_s7      <= sb_s6;
			sb_dly_q[0] <= sb_s7;
			for (int i = 1; i < LANE_LAT; i++) begin
				sb_dly_q[i] <= sb_dly_q[i-1];
			end
			done_q <= sb_o.vld;
		end
	end

	assign sb_o = sb_dly_q[LANE_LAT-1];

	always_comb begin
		rw_c  = '0;
		rx_c  = '0;
		ry_c  = '0;
		rz_c  = '0;
		sat_c = 1'b0;
		dz_c  = sb_o.dz;
		case (sb_o.cmd) inside
			CMD_MUL, CMD_INV, CMD_DIV, CMD_REL: begin
				rw_c  = q_o[0].val;
				rx_c  = q_o[1].val;
				ry_c  = q_o[2].val;
				rz_c  = q_o[3].val;
				sat_c = q_o[0].sat | q_o[1].sat | q_o[2].sat | q_o[3].sat;
			end
			CMD_ROT: begin
				rx_c  = q_o[1].val;
				ry_c  = q_o[2].val;
				rz_c  = q_o[3].val;
				sat_c = sb_o.tsat | q_o[1].sat | q_o[2].sat | q_o[3].sat;
			end
			CMD_MAG: begin
				rw_c  = sq_o.val;
				sat_c = sq_o.sat;
			end
			default: begin
			end
		endcase
		if (dz_c) begin
			rw_c  = '0;
			rx_c  = '0;
			ry_c  = '0;
			rz_c  = '0;
			sat_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		res_w_q <= rw_c;
		res_x_q <= rx_c;
		res_y_q <= ry_c;
		res_z_q <= rz_c;
		dz_q    <= dz_c;
		sat_q   <= sat_c;
	end

	assign done           = done_q;
	assign res_w          = res_w_q;
	assign res_x          = res_x_q;
	assign res_y          = res_y_q;
	assign res_z          = res_z_q;
	assign divide_by_zero = dz_q;
	assign saturated      = sat_q;

endmodule

// ===== design/qau_hamilton.sv =====
// Two-stage Hamilton product: sixteen products, then four exact sums.
module qau_hamilton import qau_pkg::*; (
	input  logic  clk,
	input  opnd_t a [4],
	input  opnd_t b [4],
	output psum_t p [4]
);

	prod_t prd_s1 [4][4];
	psum_t p_s2 [4];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prd_s1[i][j] <= a[i] * b[j];
			end
		end
		p_s2[0] <= psum_t'(prd_s1[0][0]) - psum_t'(prd_s1[1][1])
			- psum_t'(prd_s1[2][2]) - psum_t'(prd_s1[3][3]);
		p_s2[1] <= psum_t'(prd_s1[0][1]) + psum_t'(prd_s1[1][0])
			+ psum_t'(prd_s1[2][3]) - psum_t'(prd_s1[3][2]);
		p_s2[2] <= psum_t'(prd_s1[0][2]) - psum_t'(prd_s1[1][3])
			+ psum_t'(prd_s1[2][0]) + psum_t'(prd_s1[3][1]);
		p_s2[3] <= psum_t'(prd_s1[0][3]) + psum_t'(prd_s1[1][2])
			- psum_t'(prd_s1[2][1]) + psum_t'(prd_s1[3][0]);
	end

	assign p = p_s2;

endmodule

// ===== design/qau_div.sv =====
// Pipelined rounded quotient p*2^F/n, one quotient bit per stage, saturated to a word.
module qau_div import qau_pkg::*; (
	input  logic  clk,
	input  psum_t p,
	input  norm_t n,
	output lane_t res
);

	psum_t            p_abs;
	logic             neg_s1;
	logic [MW-1:0]    mag_s1;
	norm_t            n_s1;
	logic             neg_s2;
	logic [UW-1:0]    num_s2;
	logic [DW-1:0]    d_s2;
	logic             neg_s [QB+1];
	logic             ovf_s [QB+1];
	logic [DW-1:0]    d_s   [QB+1];
	logic [DW-1:0]    rem_s [QB+1];
	logic [QB-1:0]    low_s [QB+1];
	logic [QB-1:0]    quo_s [QB+1];
	logic [QB-1:0]    qf;
	logic             pos_sat;
	logic             neg_sat;
	word_t            qneg;
	lane_t            res_q;

	assign p_abs = p[PW-1] ? -p : p;

	// numerator |p|*2^(F+1) + n over 2n gives round to nearest, ties away
	always_ff @(posedge clk) begin
		neg_s1   <= p[PW-1];
		mag_s1   <= p_abs[MW-1:0];
		n_s1     <= n;
		neg_s2   <= neg_s1;
		num_s2   <= (UW'(mag_s1) << (FRAC_BITS + 1)) + UW'(n_s1);
		d_s2     <= {n_s1, 1'b0};
		neg_s[0] <= neg_s2;
		ovf_s[0] <= (num_s2 >> QB) >= UW'(d_s2);
		d_s[0]   <= d_s2;
		rem_s[0] <= DW'(num_s2 >> QB);
		low_s[0] <= num_s2[QB-1:0];
		quo_s[0] <= '0;
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW-1:0] trial;
		logic          take;

		assign trial = {rem_s[k], low_s[k][QB-1]};
		assign take  = trial >= {1'b0, d_s[k]};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? DW'(trial - {1'b0, d_s[k]}) : trial[DW-1:0];
			low_s[k+1] <= {low_s[k][QB-2:0], 1'b0};
			quo_s[k+1] <= {quo_s[k][QB-2:0], take};
			d_s[k+1]   <= d_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign qf      = quo_s[QB];
	assign pos_sat = ovf_s[QB] || (qf[QB-1:WORD_BITS-1] != '0);
	assign neg_sat = ovf_s[QB] || (qf > (QB'(1) << (WORD_BITS - 1)));
	assign qneg    = '0 - qf[WORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (neg_s[QB]) begin
			res_q.val <= neg_sat ? WORD_MIN : qneg;
			res_q.sat <= neg_sat;
		end else begin
			res_q.val <= pos_sat ? WORD_MAX : qf[WORD_BITS-1:0];
			res_q.sat <= pos_sat;
		end
	end

	assign res = res_q;

endmodule

// ===== design/qau_sqrt.sv =====
// Pipelined square root of the norm, one root bit per stage, rounded to nearest.
module qau_sqrt import qau_pkg::*; (
	input  logic  clk,
	input  norm_t n,
	output lane_t res
);

	logic [SW-1:0]  rem_s  [QB+1];
	logic [QB-1:0]  root_s [QB+1];
	logic           up_r1;
	logic [QB-1:0]  root_r1;
	logic [QB:0]    rt_r2;
	lane_t          res_q;

	always_ff @(posedge clk) begin
		rem_s[0]  <= SW'(n);
		root_s[0] <= '0;
	end

	// rem holds n - root^2; setting bit b adds root*2^(b+1) + 4^b
	for (genvar k = 0; k < QB; k++) begin : g_bit
		localparam int B = QB - 1 - k;
		logic [SW-1:0] term;
		logic          take;

		assign term = (SW'(root_s[k]) << (B + 1)) + (SW'(1) << (2 * B));
		assign take = rem_s[k] >= term;

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem_s[k] - term : rem_s[k];
			root_s[k+1] <= take ? (root_s[k] | (QB'(1) << B)) : root_s[k];
		end
	end

	always_ff @(posedge clk) begin
		up_r1     <= rem_s[QB] > SW'(root_s[QB]);
		root_r1   <= root_s[QB];
		rt_r2     <= (QB+1)'(root_r1) + (QB+1)'(up_r1);
		res_q.sat <= rt_r2[QB:WORD_BITS-1] != '0;
		res_q.val <= (rt_r2[QB:WORD_BITS-1] != '0) ? WORD_MAX : rt_r2[WORD_BITS-1:0];
	end

	assign res = res_q;

endmodule
